/* hdl/ffr_pkg.sv */
// Package for the FIFO global frame replacer: payload structs, the internal
// frame-store control structs, status codes and register indexes.
// Depends on nothing; every other file in hdl uses it by scoped names.
`default_nettype none

package ffr_pkg;

   // Sizing of the frame table and of the request fields.
   localparam int MAX_FRAMES    = 64;
   localparam int ADDR_WIDTH    = 32;
   localparam int PROCESS_COUNT = 4;

   localparam int FRAME_W = $clog2(MAX_FRAMES);      // frame index
   localparam int FILL_W  = $clog2(MAX_FRAMES + 1);  // count 0..MAX_FRAMES
   localparam int PID_W   = 2;
   localparam int VA_W    = 32;
   localparam int PAGE_W  = 32;
   localparam int COUNT_W = 32;
   localparam int SHIFT_W = 5;
   localparam int FCNT_W  = 7;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 7;

   localparam logic [FILL_W-1:0] MAX_FRAMES_FILL = FILL_W'(MAX_FRAMES);

   // Address bits kept before the page shift.
   localparam logic [VA_W-1:0] ADDR_MASK =
      (ADDR_WIDTH >= VA_W) ? {VA_W{1'b1}}
                           : VA_W'((64'(1) << ADDR_WIDTH) - 64'(1));

   // Configuration register indexes and reset values.
   localparam logic [CSR_IDX_W-1:0] REG_OFFSET_BITS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_COUNT = 2'd1;
   localparam logic [SHIFT_W-1:0]   OFFSET_RESET    = 5'd12;
   localparam logic [FCNT_W-1:0]    FRAME_CNT_RESET = 7'd64;

   // Result status codes.
   localparam logic [1:0] STATUS_HIT      = 2'd0;
   localparam logic [1:0] STATUS_FILL     = 2'd1;
   localparam logic [1:0] STATUS_EVICT    = 2'd2;
   localparam logic [1:0] STATUS_NO_FRAME = 2'd3;

   typedef struct packed {
      logic [PID_W-1:0] process_id;
      logic [VA_W-1:0]  virtual_address;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [5:0]         frame_number;
      logic [PID_W-1:0]   evicted_process;
      logic [PAGE_W-1:0]  evicted_page;
      logic [COUNT_W-1:0] fault_total;
   } rsp_type;

   // One resident page: its owner and page number.
   typedef struct packed {
      logic [PID_W-1:0]  owner;
      logic [PAGE_W-1:0] page;
   } entry_type;

   // Sequencer to frame store.
   typedef struct packed {
      logic               scan_issue;
      logic [FRAME_W-1:0] rd_addr;
      logic               wr_en;
      logic [FRAME_W-1:0] wr_addr;
      entry_type          wr_entry;
   } store_ctrl_type;

   // Frame store back to sequencer: result of the compare stage.
   typedef struct packed {
      logic               valid;
      logic [FRAME_W-1:0] idx;
      logic               match;
   } store_chk_type;

endpackage

`default_nettype wire

/* hdl/ffr_frame_store.sv */
// Frame table memory with one write port and one registered read port,
// followed by the shared key compare used by the lookup scan.
// Depends on ffr_pkg.
`default_nettype none

module ffr_frame_store (
   input  wire                     clock,
   input  wire                     reset,
   input  ffr_pkg::store_ctrl_type ctrl,
   input  ffr_pkg::entry_type      key,
   output ffr_pkg::entry_type      rd_entry,
   output ffr_pkg::store_chk_type  chk
);

   ffr_pkg::entry_type               mem [ffr_pkg::MAX_FRAMES];
   ffr_pkg::entry_type               rd_entry_ff;
   logic                             chk_vld_ff;
   logic [ffr_pkg::FRAME_W-1:0]      chk_idx_ff;

   // Memory write and registered read.
   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         mem[ctrl.wr_addr] <= ctrl.wr_entry;
      end
      rd_entry_ff <= mem[ctrl.rd_addr];
      chk_idx_ff  <= ctrl.rd_addr;
   end

   // A scan read is tagged so the compare knows the data belongs to the scan.
   always_ff @(posedge clock) begin
      if (reset) begin
         chk_vld_ff <= 1'b0;
      end else begin
         chk_vld_ff <= ctrl.scan_issue;
      end
   end

   // Shared compare: owner and page against the pending request.
   assign rd_entry  = rd_entry_ff;
   assign chk.valid = chk_vld_ff;
   assign chk.idx   = chk_idx_ff;
   assign chk.match = chk_vld_ff && (rd_entry_ff == key);

endmodule

`default_nettype wire

/* hdl/fifo_global_frame_replacer.sv */
// Top level of the FIFO global frame replacer: request sequencer, fill and
// victim bookkeeping, fault counter and configuration registers.
// Depends on ffr_pkg and ffr_frame_store.
//
//   channel  ports                                  direction  handshake
//   req      start, busy, req_data                  in         start & !busy
//   rsp      rsp_valid, rsp_data                    out        rsp_valid strobe
//   csr      csr_valid, csr_ready, csr_index, csr_wdata  in    valid & ready
//
// A request scans the resident frames one per cycle through a single
// memory read port and compare. A hit ends the scan at the matching frame;
// a miss is decided once every frame in use has been compared, and an
// eviction then adds a read state and a write state before the result.
// The result strobe is registered from the deciding cycle and cannot be
// stalled; a new request may start in the cycle the strobe is shown.
// Synchronous reset empties the table by clearing the fill count.
`default_nettype none

module fifo_global_frame_replacer (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   start,
   output logic                                  busy,
   input  ffr_pkg::req_type                      req_data,
   output logic                                  rsp_valid,
   output ffr_pkg::rsp_type                      rsp_data,
   input  wire                                   csr_valid,
   output logic                                  csr_ready,
   input  wire  [ffr_pkg::CSR_IDX_W-1:0]         csr_index,
   input  wire  [ffr_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   localparam logic [1:0] ST_IDLE     = 2'd0;
   localparam logic [1:0] ST_SCAN     = 2'd1;
   localparam logic [1:0] ST_EVICT_RD = 2'd2;
   localparam logic [1:0] ST_EVICT_WR = 2'd3;

   logic [1:0]                    state_ff, state_in;
   logic [ffr_pkg::FILL_W-1:0]    scan_ff, scan_in;
   logic [ffr_pkg::FILL_W-1:0]    used_ff, used_in;
   logic [ffr_pkg::FRAME_W-1:0]   victim_ff, victim_in;
   logic [ffr_pkg::FRAME_W-1:0]   evict_ff, evict_in;
   logic [ffr_pkg::COUNT_W-1:0]   fault_ff, fault_in;
   logic [ffr_pkg::SHIFT_W-1:0]   offset_ff;
   logic [ffr_pkg::FCNT_W-1:0]    fcount_ff;
   ffr_pkg::entry_type            key_ff, key_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   ffr_pkg::rsp_type              rsp_ff, rsp_in;

   ffr_pkg::store_ctrl_type       ctrl;
   ffr_pkg::entry_type            rd_entry;
   ffr_pkg::store_chk_type        chk;

   logic [ffr_pkg::FILL_W-1:0]    limit;
   logic [ffr_pkg::COUNT_W-1:0]   fault_inc;
   logic [ffr_pkg::FILL_W-1:0]    evict_next;
   logic                          issue;

   // Frame limit clamped to the table size.
   assign limit = (fcount_ff > ffr_pkg::FCNT_W'(ffr_pkg::MAX_FRAMES))
                  ? ffr_pkg::MAX_FRAMES_FILL : ffr_pkg::FILL_W'(fcount_ff);
   assign fault_inc  = (fault_ff == {ffr_pkg::COUNT_W{1'b1}}) ? fault_ff
                                                               : fault_ff + 1'b1;
   assign evict_next = ffr_pkg::FILL_W'(evict_ff) + 1'b1;
   assign issue      = (state_ff == ST_SCAN) && (scan_ff < used_ff);

   // Sequencer: accept (or report an unknown process), scan, then hit, fill, evict or report no frame.
   always_comb begin
      state_in     = state_ff;
      scan_in      = scan_ff;
      used_in      = used_ff;
      victim_in    = victim_ff;
      evict_in     = evict_ff;
      fault_in     = fault_ff;
      key_in       = key_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;

      ctrl.scan_issue = issue;
      ctrl.rd_addr    = (state_ff == ST_EVICT_RD) ? evict_ff
                                                  : scan_ff[ffr_pkg::FRAME_W-1:0];
      ctrl.wr_en      = 1'b0;
      ctrl.wr_addr    = used_ff[ffr_pkg::FRAME_W-1:0];
      ctrl.wr_entry   = key_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (32'(req_data.process_id) >= ffr_pkg::PROCESS_COUNT) begin
                  // Unknown process: nothing changes.
                  rsp_valid_in = 1'b1;
                  rsp_in       = '0;
                  rsp_in.status      = ffr_pkg::STATUS_HIT;
                  rsp_in.fault_total = fault_ff;
               end else begin
                  key_in.owner = req_data.process_id;
                  key_in.page  = ffr_pkg::PAGE_W'(
                     (req_data.virtual_address & ffr_pkg::ADDR_MASK) >> offset_ff);
                  scan_in  = '0;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (issue) begin
               scan_in = scan_ff + 1'b1;
            end
            if (chk.match) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '0;
               rsp_in.status       = ffr_pkg::STATUS_HIT;
               rsp_in.frame_number = 6'(chk.idx);
               rsp_in.fault_total  = fault_ff;
               state_in     = ST_IDLE;
            end else if (!issue && !chk.valid) begin
               // Miss: count the fault, then fill, evict or report no frame.
               fault_in = fault_inc;
               rsp_in   = '0;
               rsp_in.fault_total = fault_inc;
               if (used_ff < limit) begin
                  ctrl.wr_en   = 1'b1;
                  used_in      = used_ff + 1'b1;
                  rsp_valid_in = 1'b1;
                  rsp_in.status       = ffr_pkg::STATUS_FILL;
                  rsp_in.frame_number = 6'(used_ff[ffr_pkg::FRAME_W-1:0]);
                  state_in     = ST_IDLE;
               end else if (used_ff == '0) begin
                  rsp_valid_in  = 1'b1;
                  rsp_in.status = ffr_pkg::STATUS_NO_FRAME;
                  state_in      = ST_IDLE;
               end else begin
                  evict_in = (ffr_pkg::FILL_W'(victim_ff) < used_ff) ? victim_ff : '0;
                  state_in = ST_EVICT_RD;
               end
            end
         end
         ST_EVICT_RD: begin
            state_in = ST_EVICT_WR;
         end
         ST_EVICT_WR: begin
            // Old entry is on the read port; replace it and report it.
            ctrl.wr_en   = 1'b1;
            ctrl.wr_addr = evict_ff;
            victim_in    = (evict_next < used_ff) ? evict_next[ffr_pkg::FRAME_W-1:0]
                                                  : '0;
            rsp_valid_in = 1'b1;
            rsp_in.status          = ffr_pkg::STATUS_EVICT;
            rsp_in.frame_number    = 6'(evict_ff);
            rsp_in.evicted_process = rd_entry.owner;
            rsp_in.evicted_page    = rd_entry.page;
            rsp_in.fault_total     = fault_ff;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         used_ff      <= '0;
         victim_ff    <= '0;
         fault_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         victim_ff    <= victim_in;
         fault_ff     <= fault_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload and working registers.
   always_ff @(posedge clock) begin
      scan_ff  <= scan_in;
      evict_ff <= evict_in;
      key_ff   <= key_in;
      rsp_ff   <= rsp_in;
   end

   // Configuration registers, written one beat at a time.
   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= ffr_pkg::OFFSET_RESET;
         fcount_ff <= ffr_pkg::FRAME_CNT_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            ffr_pkg::REG_OFFSET_BITS: offset_ff <= csr_wdata[ffr_pkg::SHIFT_W-1:0];
            ffr_pkg::REG_FRAME_COUNT: fcount_ff <= csr_wdata[ffr_pkg::FCNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   ffr_frame_store u_store (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (ctrl),
      .key      (key_ff),
      .rd_entry (rd_entry),
      .chk      (chk)
   );

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign csr_ready = 1'b1;

   // A result always closes a request that was in progress or just started.
   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(busy) || $past(start)))
      else $error("result strobe without a request");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= ffr_pkg::MAX_FRAMES_FILL)
      else $error("fill count beyond table size");

   a_victim_in_range: assert property (@(posedge clock) disable iff (reset)
      (victim_ff == '0) || (ffr_pkg::FILL_W'(victim_ff) < used_ff))
      else $error("victim pointer outside filled frames");

   a_fault_monotonic: assert property (@(posedge clock) disable iff (reset)
      fault_ff >= $past(fault_ff))
      else $error("fault counter went backward");

   // The fill count steps up by one on the edge that decides a fill.
   a_fill_grows_on_fill: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == ffr_pkg::STATUS_FILL) |->
         (used_ff == $past(used_ff) + 1'b1 && used_ff != '0))
      else $error("fill result without fill count update");

endmodule

`default_nettype wire

/* sim/tb_fifo_global_frame_replacer.sv */
// Testbench for the FIFO global frame replacer: directed page-table cases, then
// random accesses mostly drawn from working sets, with every result checked in order.
// Depends on ffr_pkg and the fifo_global_frame_replacer RTL.
`default_nettype none

module tb_fifo_global_frame_replacer;

   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int SETTLE_CYCLES = 4;
   localparam int TAIL_CYCLES = 70;
   localparam int POOL_MAX = 96;
   localparam int BLOCK_ITEMS = 103;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   ffr_pkg::req_type req_data = '0;
   logic rsp_valid;
   ffr_pkg::rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [ffr_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [ffr_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   // Shadow of the frame table, used to predict each result.
   logic frame_live [ffr_pkg::MAX_FRAMES];
   logic [ffr_pkg::PID_W-1:0] frame_owner [ffr_pkg::MAX_FRAMES];
   logic [ffr_pkg::PAGE_W-1:0] frame_page [ffr_pkg::MAX_FRAMES];
   int unsigned fill_count;
   int unsigned victim_ptr;
   logic [ffr_pkg::COUNT_W-1:0] fault_tally;
   logic [ffr_pkg::SHIFT_W-1:0] shift_cfg;
   logic [ffr_pkg::FCNT_W-1:0] frame_limit_cfg;

   ffr_pkg::rsp_type expected_rsp [$];
   ffr_pkg::rsp_type front_rsp;
   int mismatch_count = 0;
   int idle_pct = 27;
   int unsigned cycle_count = 0;

   fifo_global_frame_replacer dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   // Give up if the run hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // Work out the result of one access and update the shadow table.
   function automatic ffr_pkg::rsp_type translate_access(input ffr_pkg::req_type item);
      ffr_pkg::rsp_type res;
      logic [ffr_pkg::PAGE_W-1:0] page;
      int unsigned limit;
      int unsigned f;
      int i;
      res = '0;
      page = (item.virtual_address & ffr_pkg::ADDR_MASK) >> shift_cfg;
      limit = (frame_limit_cfg > ffr_pkg::MAX_FRAMES) ? ffr_pkg::MAX_FRAMES
                                                       : frame_limit_cfg;
      if (int'(item.process_id) >= ffr_pkg::PROCESS_COUNT) begin
         res.fault_total = fault_tally;
         return res;
      end
      for (i = 0; i < ffr_pkg::MAX_FRAMES; i++) begin
         if (frame_live[i] && frame_owner[i] == item.process_id
             && frame_page[i] == page) begin
            res.status = ffr_pkg::STATUS_HIT;
            res.frame_number = 6'(i);
            res.fault_total = fault_tally;
            return res;
         end
      end
      if (fault_tally != '1)
         fault_tally = fault_tally + 1'b1;
      res.fault_total = fault_tally;
      if (fill_count < limit && fill_count < ffr_pkg::MAX_FRAMES) begin
         f = fill_count;
         frame_live[f] = 1'b1;
         frame_owner[f] = item.process_id;
         frame_page[f] = page;
         fill_count++;
         res.status = ffr_pkg::STATUS_FILL;
         res.frame_number = 6'(f);
         return res;
      end
      if (fill_count == 0) begin
         res.status = ffr_pkg::STATUS_NO_FRAME;
         return res;
      end
      // Table full: reuse the oldest frame, round robin over filled frames.
      f = (victim_ptr < fill_count) ? victim_ptr : 0;
      res.status = ffr_pkg::STATUS_EVICT;
      res.frame_number = 6'(f);
      res.evicted_process = frame_owner[f];
      res.evicted_page = frame_page[f];
      frame_owner[f] = item.process_id;
      frame_page[f] = page;
      victim_ptr = (f + 1 < fill_count) ? f + 1 : 0;
      return res;
   endfunction

   function automatic ffr_pkg::req_type access(input logic [ffr_pkg::PID_W-1:0] pid,
                                                input logic [ffr_pkg::VA_W-1:0] va);
      ffr_pkg::req_type item;
      item.process_id = pid;
      item.virtual_address = va;
      return item;
   endfunction

   // Send one access beat after a random gap; start stays high across back-to-back beats.
   task automatic send_access(input ffr_pkg::req_type item);
      int gap;
      ffr_pkg::rsp_type pred;
      gap = 0;
      while (gap < 20 && $urandom_range(99) < idle_pct)
         gap++;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      pred = translate_access(item);
      expected_rsp = {expected_rsp, pred};
   endtask

   // Stop issuing and wait until every pending result has come back.
   task automatic settle();
      start <= 1'b0;
      while (expected_rsp.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One register write beat; only called while the block is idle.
   task automatic write_csr(input logic [ffr_pkg::CSR_IDX_W-1:0] idx,
                            input logic [ffr_pkg::CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      if (idx == ffr_pkg::REG_OFFSET_BITS)
         shift_cfg = data[ffr_pkg::SHIFT_W-1:0];
      else if (idx == ffr_pkg::REG_FRAME_COUNT)
         frame_limit_cfg = data;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         mismatch_count++;
      end
   endtask

   // Compare each result beat with the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_rsp.size() == 0) begin
            $error("result beat with no access pending");
            mismatch_count++;
         end else begin
            front_rsp = expected_rsp.pop_front();
            check_field("status", 32'(front_rsp.status), 32'(rsp_data.status));
            check_field("frame_number", 32'(front_rsp.frame_number),
                        32'(rsp_data.frame_number));
            check_field("evicted_process", 32'(front_rsp.evicted_process),
                        32'(rsp_data.evicted_process));
            check_field("evicted_page", front_rsp.evicted_page, rsp_data.evicted_page);
            check_field("fault_total", front_rsp.fault_total, rsp_data.fault_total);
         end
      end
   end

   // With no frames at all and an empty table, every access faults with no frame.
   task automatic test_no_frames();
      write_csr(ffr_pkg::REG_FRAME_COUNT, 7'd0);
      send_access(access(2'd0, 32'h0000_0000));
      send_access(access(2'd3, 32'hFFFF_FFFF));
      settle();
   endtask

   // Fill a three-frame table, hit on a resident page, then evict in fill order.
   task automatic test_fill_and_evict();
      write_csr(ffr_pkg::REG_OFFSET_BITS, 7'd0);
      write_csr(ffr_pkg::REG_FRAME_COUNT, 7'd3);
      send_access(access(2'd0, 32'h0000_0000));
      send_access(access(2'd1, 32'h0000_0000));
      send_access(access(2'd0, 32'h0000_0000));
      send_access(access(2'd2, 32'hFFFF_FFFF));
      send_access(access(2'd3, 32'h0000_0005));
      send_access(access(2'd0, 32'h0000_0000));
      settle();
   endtask

   // Lowering the frame count keeps evicting over the frames already filled.
   task automatic test_shrink();
      write_csr(ffr_pkg::REG_FRAME_COUNT, 7'd1);
      send_access(access(2'd1, 32'h0000_0010));
      send_access(access(2'd2, 32'h0000_0011));
      send_access(access(2'd3, 32'h0000_0012));
      settle();
   endtask

   // Raising the frame count fills the new frames before evicting again.
   task automatic test_grow();
      write_csr(ffr_pkg::REG_OFFSET_BITS, 7'd31);
      write_csr(ffr_pkg::REG_FRAME_COUNT, 7'd5);
      send_access(access(2'd1, 32'h8000_0000));
      send_access(access(2'd1, 32'h7FFF_FFFF));
      send_access(access(2'd2, 32'hFFFF_FFFF));
      send_access(access(2'd1, 32'h0000_0001));
      settle();
   endtask

   // A frame count beyond the table size acts as the full table.
   task automatic test_above_limit();
      write_csr(ffr_pkg::REG_OFFSET_BITS, 7'd12);
      write_csr(ffr_pkg::REG_FRAME_COUNT, 7'd127);
      send_access(access(2'd3, 32'hFFFF_FFFF));
      send_access(access(2'd3, 32'hFFFF_F000));
      send_access(access(2'd0, 32'h0000_0FFF));
      send_access(access(2'd2, 32'h0001_2345));
      settle();
   endtask

   // Random accesses mostly drawn from a working set, under a random setting.
   task automatic test_random_block(input int item_total);
      logic [ffr_pkg::PID_W-1:0] pool_pid [POOL_MAX];
      logic [ffr_pkg::PAGE_W-1:0] pool_page [POOL_MAX];
      int pool_size;
      int k;
      logic [31:0] low_mask;
      ffr_pkg::req_type item;
      case ($urandom_range(2))
         0: write_csr(ffr_pkg::REG_OFFSET_BITS, 7'd0);
         1: write_csr(ffr_pkg::REG_OFFSET_BITS, 7'd31);
         default: write_csr(ffr_pkg::REG_OFFSET_BITS, 7'($urandom_range(31)));
      endcase
      case ($urandom_range(5))
         0: write_csr(ffr_pkg::REG_FRAME_COUNT, 7'd0);
         1: write_csr(ffr_pkg::REG_FRAME_COUNT, 7'($urandom_range(8, 1)));
         2: write_csr(ffr_pkg::REG_FRAME_COUNT, 7'd64);
         3: write_csr(ffr_pkg::REG_FRAME_COUNT, 7'd127);
         default: write_csr(ffr_pkg::REG_FRAME_COUNT, 7'($urandom_range(127)));
      endcase
      pool_size = $urandom_range(POOL_MAX, 2);
      for (k = 0; k < pool_size; k++) begin
         pool_pid[k] = ffr_pkg::PID_W'($urandom);
         pool_page[k] = $urandom;
      end
      low_mask = (shift_cfg == 0) ? 32'h0 : (32'hFFFF_FFFF >> (32 - shift_cfg));
      repeat (item_total) begin
         if ($urandom_range(99) < 85) begin
            k = $urandom_range(pool_size - 1);
            item.process_id = pool_pid[k];
            item.virtual_address = (pool_page[k] << shift_cfg) | ($urandom & low_mask);
         end else begin
            item.process_id = ffr_pkg::PID_W'($urandom);
            item.virtual_address = $urandom;
         end
         send_access(item);
      end
      settle();
   endtask

   initial begin
      int mode;
      int blk;
      int idle_modes [3];
      idle_modes = '{27, 78, 0};
      for (blk = 0; blk < ffr_pkg::MAX_FRAMES; blk++)
         frame_live[blk] = 1'b0;
      fill_count = 0;
      victim_ptr = 0;
      fault_tally = '0;
      shift_cfg = ffr_pkg::OFFSET_RESET;
      frame_limit_cfg = ffr_pkg::FRAME_CNT_RESET;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_no_frames();
      test_fill_and_evict();
      test_shrink();
      test_grow();
      test_above_limit();

      for (mode = 0; mode < 3; mode++) begin
         idle_pct = idle_modes[mode];
         for (blk = 0; blk < 5; blk++)
            test_random_block(BLOCK_ITEMS);
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

`default_nettype wire
